/* src/wps_pkg.sv */
// Shared types and constants for the WAV PCM stream parser.
package wps_pkg;

  // Bytes of file header that may pass before the fmt chunk must appear.
  localparam int unsigned HEADER_WINDOW = 16384;
  // A chunk fails the window check when offset + size exceeds this value.
  localparam logic [32:0] WINDOW_LIMIT = 33'(HEADER_WINDOW - 9);

  // Chunk tags as little-endian words.
  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6d66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  // Result kinds.
  localparam logic [1:0] KIND_FORMAT    = 2'd0;
  localparam logic [1:0] KIND_SAMPLE    = 2'd1;
  localparam logic [1:0] KIND_ERROR     = 2'd2;
  localparam logic [1:0] KIND_END_AUDIO = 2'd3;

  // Allowed sample rates and sample widths.
  localparam logic [31:0] RATE_44K1  = 32'd44100;
  localparam logic [31:0] RATE_48K   = 32'd48000;
  localparam logic [31:0] RATE_88K2  = 32'd88200;
  localparam logic [31:0] RATE_96K   = 32'd96000;
  localparam logic [31:0] RATE_176K4 = 32'd176400;
  localparam logic [31:0] RATE_192K  = 32'd192000;
  localparam logic [15:0] BITS_16    = 16'd16;
  localparam logic [15:0] BITS_24    = 16'd24;

  // Input beat: one byte of the file.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_stream;
  } in_beat_t;

  // Output beat: one result.
  typedef struct packed {
    logic [1:0]         kind;
    logic signed [23:0] sample;
    logic               channel;
    logic [31:0]        sample_rate;
    logic [15:0]        channel_count;
    logic [15:0]        sample_bits;
    logic [31:0]        byte_rate;
    logic [31:0]        data_bytes;
    logic               last;
  } out_beat_t;

  // Results produced by one parsed byte, pushed into the output queue.
  typedef struct packed {
    logic [1:0] n;
    out_beat_t  first;
    out_beat_t  second;
  } push_t;

endpackage

/* src/wps_core.sv */
// Parser state and the per-byte update of the RIFF/WAVE walk.
module wps_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  wps_pkg::in_beat_t beat,
  output wps_pkg::push_t    push
);

  typedef enum logic [2:0] {
    PH_RIFF,
    PH_CHDR,
    PH_BODY,
    PH_DATA,
    PH_IDLE
  } phase_t;

  phase_t      phase, phase_next;
  logic [31:0] header_offset, header_offset_next;
  logic [31:0] chunk_pos, chunk_pos_next;
  logic [31:0] chunk_tag, chunk_tag_next;
  logic [31:0] chunk_len, chunk_len_next;
  logic        fmt_seen, fmt_seen_next;
  logic [15:0] chan_reg, chan_reg_next;
  logic [31:0] rate_reg, rate_reg_next;
  logic [31:0] byterate_reg, byterate_reg_next;
  logic [15:0] width_reg, width_reg_next;
  logic [31:0] data_left, data_left_next;
  logic [23:0] sample_acc, sample_acc_next;
  logic [1:0]  byte_in_sample, byte_in_sample_next;
  logic        chan_toggle, chan_toggle_next;

  function automatic logic [31:0] set_byte32(logic [31:0] w, logic [1:0] idx, logic [7:0] b);
    logic [31:0] r;
    r = w;
    case (idx)
      2'd0:    r[7:0]   = b;
      2'd1:    r[15:8]  = b;
      2'd2:    r[23:16] = b;
      default: r[31:24] = b;
    endcase
    return r;
  endfunction

  function automatic logic [23:0] set_byte24(logic [23:0] w, logic [1:0] idx, logic [7:0] b);
    logic [23:0] r;
    r = w;
    case (idx)
      2'd0:    r[7:0]   = b;
      2'd1:    r[15:8]  = b;
      2'd2:    r[23:16] = b;
      default: r = w;
    endcase
    return r;
  endfunction

  function automatic logic rate_ok(logic [31:0] r);
    return r == wps_pkg::RATE_44K1 || r == wps_pkg::RATE_48K ||
           r == wps_pkg::RATE_88K2 || r == wps_pkg::RATE_96K ||
           r == wps_pkg::RATE_176K4 || r == wps_pkg::RATE_192K;
  endfunction

  logic [7:0]  b;
  logic        eos;
  logic [31:0] pos;
  logic [31:0] pos_inc;
  logic [31:0] tag_new;
  logic [31:0] len_new;
  logic [23:0] acc_new;
  logic [1:0]  bis_new;
  logic [31:0] left_new;
  logic        window_over;
  logic        fmt_capture;
  logic        fail;

  assign b       = beat.data_byte;
  assign eos     = beat.end_of_stream;
  assign pos     = chunk_pos;
  assign pos_inc = chunk_pos + 32'd1;

  // Byte update of one step; results go to the queue as one or two beats.
  always_comb begin
    phase_next          = phase;
    header_offset_next  = header_offset;
    chunk_pos_next      = chunk_pos;
    chunk_tag_next      = chunk_tag;
    chunk_len_next      = chunk_len;
    fmt_seen_next       = fmt_seen;
    chan_reg_next       = chan_reg;
    rate_reg_next       = rate_reg;
    byterate_reg_next   = byterate_reg;
    width_reg_next      = width_reg;
    data_left_next      = data_left;
    sample_acc_next     = sample_acc;
    byte_in_sample_next = byte_in_sample;
    chan_toggle_next    = chan_toggle;
    push                = '0;
    fail                = 1'b0;

    tag_new     = set_byte32(chunk_tag, pos[1:0], b);
    len_new     = set_byte32(chunk_len, pos[1:0], b);
    acc_new     = set_byte24(sample_acc, byte_in_sample, b);
    bis_new     = byte_in_sample + 2'd1;
    left_new    = data_left - 32'd1;
    window_over = ({1'b0, header_offset} + {1'b0, len_new}) > wps_pkg::WINDOW_LIMIT;
    fmt_capture = (chunk_tag == wps_pkg::TAG_FMT) && !fmt_seen && (pos[31:4] == 28'd0);

    if (step && phase != PH_IDLE) begin
      if (header_offset != 32'hFFFF_FFFF) begin
        header_offset_next = header_offset + 32'd1;
      end
      case (phase)
        // RIFF and WAVE magic words.
        PH_RIFF: begin
          chunk_tag_next = tag_new;
          chunk_pos_next = pos_inc;
          if (pos == 32'd3 && tag_new != wps_pkg::TAG_RIFF) begin
            fail = 1'b1;
          end else if (pos == 32'd11) begin
            if (tag_new != wps_pkg::TAG_WAVE) begin
              fail = 1'b1;
            end else begin
              chunk_pos_next = '0;
              phase_next     = PH_CHDR;
            end
          end
          if (eos) begin
            fail = 1'b1;
          end
        end
        // Eight-byte chunk header: tag, then size.
        PH_CHDR: begin
          if (pos[31:2] == 30'd0) begin
            chunk_tag_next = tag_new;
          end else begin
            chunk_len_next = len_new;
          end
          chunk_pos_next = pos_inc;
          if (pos == 32'd7) begin
            if (chunk_tag == wps_pkg::TAG_DATA) begin
              if (!fmt_seen || !rate_ok(rate_reg) ||
                  (width_reg != wps_pkg::BITS_16 && width_reg != wps_pkg::BITS_24)) begin
                fail = 1'b1;
              end else begin
                push.n                    = 2'd1;
                push.first.kind           = wps_pkg::KIND_FORMAT;
                push.first.sample_rate    = rate_reg;
                push.first.channel_count  = chan_reg;
                push.first.sample_bits    = width_reg;
                push.first.byte_rate      = byterate_reg;
                push.first.data_bytes     = len_new;
                push.first.last           = 1'b1;
                data_left_next            = len_new;
                sample_acc_next           = '0;
                byte_in_sample_next       = '0;
                chan_toggle_next          = 1'b0;
                if (len_new == 32'd0 || eos) begin
                  phase_next        = PH_IDLE;
                  push.n            = 2'd2;
                  push.first.last   = 1'b0;
                  push.second.kind  = wps_pkg::KIND_END_AUDIO;
                  push.second.last  = 1'b1;
                end else begin
                  phase_next = PH_DATA;
                end
              end
            end else if (eos) begin
              fail = 1'b1;
            end else if (!fmt_seen && chunk_tag != wps_pkg::TAG_FMT && window_over) begin
              fail = 1'b1;
            end else begin
              chunk_pos_next = '0;
              if (len_new == 32'd0) begin
                if (chunk_tag == wps_pkg::TAG_FMT) begin
                  fmt_seen_next = 1'b1;
                end
                phase_next = PH_CHDR;
              end else begin
                phase_next = PH_BODY;
              end
            end
          end else if (eos) begin
            fail = 1'b1;
          end
        end
        // Chunk body: capture fmt fields, skip everything else.
        PH_BODY: begin
          if (fmt_capture) begin
            case (pos[3:0])
              4'd2, 4'd3: begin
                if (pos[0]) chan_reg_next[15:8] = b;
                else        chan_reg_next[7:0]  = b;
              end
              4'd4, 4'd5, 4'd6, 4'd7: rate_reg_next = set_byte32(rate_reg, pos[1:0], b);
              4'd8, 4'd9, 4'd10, 4'd11: begin
                byterate_reg_next = set_byte32(byterate_reg, pos[1:0], b);
              end
              4'd14, 4'd15: begin
                if (pos[0]) width_reg_next[15:8] = b;
                else        width_reg_next[7:0]  = b;
              end
              default: ;
            endcase
          end
          chunk_pos_next = pos_inc;
          if (pos_inc == chunk_len) begin
            if (chunk_tag == wps_pkg::TAG_FMT) begin
              fmt_seen_next = 1'b1;
            end
            chunk_pos_next = '0;
            phase_next     = PH_CHDR;
          end
          if (eos) begin
            fail = 1'b1;
          end
        end
        // Audio payload: assemble samples, stop at size or end of stream.
        PH_DATA: begin
          data_left_next = left_new;
          if ((width_reg == wps_pkg::BITS_24) ? (bis_new == 2'd3) : (bis_new >= 2'd2)) begin
            push.n          = 2'd1;
            push.first.kind = wps_pkg::KIND_SAMPLE;
            push.first.last = 1'b1;
            if (width_reg == wps_pkg::BITS_24) begin
              push.first.sample = acc_new;
            end else begin
              push.first.sample = {acc_new[15:0], 8'h00};
            end
            if (chan_reg == 16'd2) begin
              push.first.channel = chan_toggle;
              chan_toggle_next   = ~chan_toggle;
            end
            sample_acc_next     = '0;
            byte_in_sample_next = '0;
          end else begin
            sample_acc_next     = acc_new;
            byte_in_sample_next = bis_new;
          end
          if (left_new == 32'd0 || eos) begin
            phase_next = PH_IDLE;
            if (push.n == 2'd1) begin
              push.n           = 2'd2;
              push.first.last  = 1'b0;
              push.second.kind = wps_pkg::KIND_END_AUDIO;
              push.second.last = 1'b1;
            end else begin
              push.n          = 2'd1;
              push.first.kind = wps_pkg::KIND_END_AUDIO;
              push.first.last = 1'b1;
            end
          end
        end
        default: ;
      endcase

      // A format error is always the only result of its byte.
      if (fail) begin
        phase_next      = PH_IDLE;
        push            = '0;
        push.n          = 2'd1;
        push.first.kind = wps_pkg::KIND_ERROR;
        push.first.last = 1'b1;
      end
    end
  end

  // Parser state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_RIFF;
      header_offset  <= '0;
      chunk_pos      <= '0;
      chunk_tag      <= '0;
      chunk_len      <= '0;
      fmt_seen       <= 1'b0;
      chan_reg       <= '0;
      rate_reg       <= '0;
      byterate_reg   <= '0;
      width_reg      <= '0;
      data_left      <= '0;
      sample_acc     <= '0;
      byte_in_sample <= '0;
      chan_toggle    <= 1'b0;
    end else begin
      phase          <= phase_next;
      header_offset  <= header_offset_next;
      chunk_pos      <= chunk_pos_next;
      chunk_tag      <= chunk_tag_next;
      chunk_len      <= chunk_len_next;
      fmt_seen       <= fmt_seen_next;
      chan_reg       <= chan_reg_next;
      rate_reg       <= rate_reg_next;
      byterate_reg   <= byterate_reg_next;
      width_reg      <= width_reg_next;
      data_left      <= data_left_next;
      sample_acc     <= sample_acc_next;
      byte_in_sample <= byte_in_sample_next;
      chan_toggle    <= chan_toggle_next;
    end
  end

`ifndef SYNTHESIS
  // An idle parser produces nothing.
  a_idle_silent: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_IDLE) |-> (push.n == 2'd0))
    else $error("results pushed while parser idle");

  // Two results in one step only happen at the end of audio.
  a_pair_ends: assert property (@(posedge clk) disable iff (rst)
    (push.n == 2'd2) |=> (phase == PH_IDLE))
    else $error("two results without ending the stream");

  // The sample byte counter never reaches three in the data phase.
  a_bis_range: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_DATA) |-> (byte_in_sample != 2'd3))
    else $error("sample byte counter out of range");
`endif

endmodule

/* src/wps_out_queue.sv */
// Four-entry result queue that takes up to two beats per cycle.
module wps_out_queue (
  input  logic               clk,
  input  logic               rst,
  input  wps_pkg::push_t     push,
  output logic               room,
  output logic               head_valid,
  input  logic               head_ready,
  output wps_pkg::out_beat_t head
);

  wps_pkg::out_beat_t slots [4];
  logic [1:0] wr_ptr, wr_ptr_next;
  logic [1:0] rd_ptr, rd_ptr_next;
  logic [2:0] count, count_next;
  logic       pop;

  assign head_valid = (count != 3'd0);
  assign head       = slots[rd_ptr];
  assign room       = (count <= 3'd2);
  assign pop        = head_valid && head_ready;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_next = wr_ptr + push.n;
    rd_ptr_next = rd_ptr + {1'b0, pop};
    count_next  = count + {1'b0, push.n} - {2'b00, pop};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
    end
  end

  // Result storage.
  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      slots[wr_ptr] <= push.first;
    end
    if (push.n == 2'd2) begin
      slots[wr_ptr + 2'd1] <= push.second;
    end
  end

`ifndef SYNTHESIS
  // The fill count never passes the depth.
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= 3'd4)
    else $error("result queue overflow");

  // Results only arrive when two slots are free.
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    (push.n != 2'd0) |-> room)
    else $error("push without room in result queue");

  // A stalled head beat keeps its contents.
  a_head_hold: assert property (@(posedge clk) disable iff (rst)
    (head_valid && !head_ready) |=> $stable(head))
    else $error("head beat changed while stalled");
`endif

endmodule

/* src/wav_pcm_stream_parser.sv */
// Top level of the WAV PCM stream parser: input register, parser, result queue.
//
//  channel   handshake                     payload      direction
//  byte      byte_valid / byte_ready       byte_beat    in
//  result    result_valid / result_ready   result_beat  out
//
// One byte is accepted per cycle while the input register is empty or the queue
// has room; a held byte steps the parser and the queue registers its results.
// The rate is set by the four-entry result queue: the parser advances only while
// two slots are free; results drain at one a cycle while result_ready is high.
// A byte yields at most one result except at the end of audio.
// Reset is synchronous; the parser starts at the RIFF magic with empty queue.
module wav_pcm_stream_parser (
  input  logic               clk,
  input  logic               rst,
  input  logic               byte_valid,
  output logic               byte_ready,
  input  wps_pkg::in_beat_t  byte_beat,
  output logic               result_valid,
  input  logic               result_ready,
  output wps_pkg::out_beat_t result_beat
);

  logic              hold_full;
  wps_pkg::in_beat_t hold;
  logic              room;
  logic              take;
  wps_pkg::push_t    push;

  // The held byte goes to the parser when the queue has room for its results.
  assign take       = hold_full && room;
  assign byte_ready = !hold_full || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_full <= 1'b0;
    end else if (byte_ready) begin
      hold_full <= byte_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_ready && byte_valid) begin
      hold <= byte_beat;
    end
  end

  wps_core u_core (
    .clk  (clk),
    .rst  (rst),
    .step (take),
    .beat (hold),
    .push (push)
  );

  wps_out_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .room       (room),
    .head_valid (result_valid),
    .head_ready (result_ready),
    .head       (result_beat)
  );

endmodule
